>>> rtl/core/zvd_pkg.sv
// zvd_pkg: shared constants, status codes and structs for the zigzag varint decoder.
// No dependencies; imported by zvd_step, zigzag_varint_decoder and the testbench.
package zvd_pkg;

  // Decoded word width and derived limits
  localparam int WORD_BITS = 64;
  localparam int ACC_W     = WORD_BITS - 1;            // magnitude bits
  localparam int MAXB      = (WORD_BITS + 6) / 7;      // bytes per number, at most
  localparam int LASTBITS  = WORD_BITS + 7 - 7 * MAXB; // usable payload bits in last byte
  localparam int CNT_W     = $clog2(MAXB);
  localparam int SH_W      = $clog2(WORD_BITS);
  localparam int STAT_W    = 2;

  localparam logic [7:0] MORE_BIT_MASK = 8'h80;
  localparam logic [6:0] PAYLOAD_MASK  = 7'h7F;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAXB - 1);

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_NEG_UNS  = 2'd3
  } zvd_status_t;

  // Running decode state of the number in progress
  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [CNT_W-1:0] count;
    logic             sign;
  } zvd_state_t;

  // Outcome of one byte
  typedef struct packed {
    logic                 emit;
    logic [WORD_BITS-1:0] value;
    zvd_status_t          status;
  } zvd_res_t;

endpackage

>>> rtl/core/zvd_step.sv
// zvd_step: combinational decode of one byte against the running state.
// Depends on zvd_pkg for widths, status codes and the state/result structs.
module zvd_step (
  input  logic [7:0]         byte_in,
  input  logic               signed_mode,
  input  zvd_pkg::zvd_state_t st,
  output zvd_pkg::zvd_state_t st_nxt,
  output zvd_pkg::zvd_res_t   res
);
  import zvd_pkg::*;

  logic [6:0]       payload;
  logic             more;
  logic             last;
  logic [SH_W:0]    sh_full;
  logic [SH_W-1:0]  sh;
  logic [ACC_W-1:0] acc_new;
  logic             sign_new;
  logic             ovf;

  assign payload = byte_in[6:0] & PAYLOAD_MASK;
  assign more    = (byte_in & MORE_BIT_MASK) != 8'h00;
  assign last    = (st.count == LAST_IDX);

  // Shift for byte k is 7k-1 (first byte carries the sign in bit 0)
  assign sh_full = (SH_W+1)'({st.count, 3'b000}) - (SH_W+1)'(st.count) - (SH_W+1)'(1);
  assign sh      = sh_full[SH_W-1:0];

  // Shift-or of the payload into the accumulator
  always_comb begin
    if (st.count == '0) begin
      acc_new  = ACC_W'(payload[6:1]);
      sign_new = payload[0];
    end else begin
      acc_new  = st.acc | (ACC_W'(payload) << sh);
      sign_new = st.sign;
    end
  end

  assign ovf = last && ((payload >> LASTBITS) != 7'd0);

  // Result selection and next state
  always_comb begin
    res.emit   = 1'b0;
    res.value  = '0;
    res.status = ST_OK;
    st_nxt.acc   = acc_new;
    st_nxt.count = st.count + CNT_W'(1);
    st_nxt.sign  = sign_new;
    if (more) begin
      if (last) begin
        res.emit   = 1'b1;
        res.status = ST_TOO_LONG;
      end
    end else begin
      res.emit = 1'b1;
      if (ovf) begin
        res.status = ST_OVERFLOW;
      end else if (sign_new && !signed_mode) begin
        res.status = ST_NEG_UNS;
      end else if (sign_new) begin
        res.value = {1'b1, ~acc_new};
      end else begin
        res.value = {1'b0, acc_new};
      end
    end
    // Restart after any result
    if (res.emit) begin
      st_nxt.acc   = '0;
      st_nxt.count = '0;
      st_nxt.sign  = 1'b0;
    end
  end

endmodule

>>> rtl/core/zigzag_varint_decoder.sv
// Zigzag LEB128 varint decoder, one byte beat per cycle unless the output stalls.
// Result path: the last byte of a number is decoded from the input register into the output
// register, which drives out_*.
// Throughput: 1 byte per cycle unless out_ready stalls, set by the combinational shift-or.
// Reset (rst_n low, synchronous): pipeline empty, decode state cleared, signed_mode = 1.
// Depends on zvd_pkg and zvd_step.
module zigzag_varint_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [zvd_pkg::WORD_BITS-1:0] out_value,
  output logic [zvd_pkg::STAT_W-1:0]     out_status
);
  import zvd_pkg::*;

  logic                 signed_mode_r;
  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  zvd_state_t           st_r, st_nxt;
  zvd_res_t             res;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_value_r;
  logic [STAT_W-1:0]    out_status_r;
  logic                 out_free;
  logic                 s1_adv;

  // Handshake: each stage moves when the one after it has room
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b1;
    end else if (cfg_we) begin
      signed_mode_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte_in;
    end
  end

  zvd_step u_step (
    .byte_in     (s1_byte_r),
    .signed_mode (signed_mode_r),
    .st          (st_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  // Decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) begin
      out_value_r  <= res.value;
      out_status_r <= res.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_value_r == '0))
    else $error("error result with nonzero value");

  // Byte count never reaches the per-number limit
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.count < CNT_W'(MAXB))
    else $error("byte count out of range");

  // A result restarts the number
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res.emit |=> (st_r.count == '0) && (st_r.acc == '0) && !st_r.sign)
    else $error("state not cleared after result");

  // Decode state moves only when a byte leaves the input register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(st_r))
    else $error("decode state changed without a byte");
`endif

endmodule

>>> tb/sv/tb_zigzag_varint_decoder.sv
// Self-checking testbench for zigzag_varint_decoder: byte beats in, decoded words out.
// Predicts each decoded word in a small scoreboard class and checks it per field.
// Depends on zvd_pkg and the decoder RTL.
module tb_zigzag_varint_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import zvd_pkg::*;

  localparam int FLUSH_CYCLES = 8;      // idle wait after the last predicted word is out
  localparam int PHASE_BYTES  = 95;     // minimum random bytes per random phase

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    zvd_status_t          status;
  } decoded_t;

  // Predicts decoded words from accepted bytes and checks the words that come out
  class varint_tracker;
    bit               signed_mode;
    logic [ACC_W-1:0] acc;
    int unsigned      nbytes;
    bit               sign;
    decoded_t         expected_q[$];
    int unsigned      mismatches;
    int unsigned      bytes_seen;
    int unsigned      words_seen;
    int unsigned      by_status[4];

    function new();
      signed_mode = 1'b1;
      restart();
    endfunction

    function void restart();
      acc    = '0;
      nbytes = 0;
      sign   = 1'b0;
    endfunction

    function void finish_number(logic [WORD_BITS-1:0] v, zvd_status_t st);
      decoded_t w;
      w.value  = v;
      w.status = st;
      expected_q.push_back(w);
      restart();
    endfunction

    // Fold one accepted byte into the number in progress
    function void take_byte(logic [7:0] b);
      logic [6:0]           payload;
      logic [WORD_BITS-1:0] wide;
      int unsigned          k;
      bit                   last;
      payload = b[6:0] & PAYLOAD_MASK;
      k       = (nbytes > MAXB - 1) ? MAXB - 1 : nbytes;
      last    = (k == MAXB - 1);
      bytes_seen++;
      if (k == 0) begin
        sign = payload[0];
        acc  = ACC_W'(payload >> 1);
      end else begin
        wide = WORD_BITS'(payload) << (7 * k - 1);
        acc  = acc | wide[ACC_W-1:0];
      end
      if ((b & MORE_BIT_MASK) != 0) begin
        if (last) finish_number('0, ST_TOO_LONG);
        else nbytes = k + 1;
      end else if (last && (payload >> LASTBITS) != 0) begin
        finish_number('0, ST_OVERFLOW);
      end else if (sign && !signed_mode) begin
        finish_number('0, ST_NEG_UNS);
      end else begin
        // zigzag: odd codes map to -m-1, i.e. the complement of m
        finish_number(sign ? ~{1'b0, acc} : {1'b0, acc}, ST_OK);
      end
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    function void check_word(logic [WORD_BITS-1:0] v, logic [STAT_W-1:0] st);
      decoded_t want;
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word value=%h status=%0d", v, st));
        return;
      end
      want = expected_q.pop_front();
      words_seen++;
      by_status[want.status]++;
      if (st !== want.status)
        note_mismatch($sformatf("status exp=%0d act=%0d", want.status, st));
      if (v !== want.value)
        note_mismatch($sformatf("value exp=%h act=%h", want.value, v));
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic                        cfg_wdata;
  logic                        in_valid;
  logic                        in_ready;
  logic [7:0]                  in_byte_in;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [WORD_BITS-1:0] out_value;
  logic [STAT_W-1:0]           out_status;

  varint_tracker sb;
  logic [7:0]    byte_q[$];
  bit            no_idle;

  always #6 clk = ~clk;

  zigzag_varint_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte_in(in_byte_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .out_status(out_status)
  );

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  // Zigzag + LEB128 encode, optionally padded with redundant continuation bytes
  function automatic void queue_number(logic signed [WORD_BITS-1:0] v, int pad);
    logic [WORD_BITS-1:0] z;
    logic [WORD_BITS-1:0] rest;
    logic [7:0]           b;
    int                   total;
    z     = (v <<< 1) ^ {WORD_BITS{v[WORD_BITS-1]}};
    total = 1;
    for (rest = z >> 7; rest != 0; rest = rest >> 7) total++;
    total = (total + pad > MAXB) ? MAXB : total + pad;
    for (int i = 0; i < total; i++) begin
      b = {1'b0, z[6:0]};
      z = z >> 7;
      if (i != total - 1) b = b | MORE_BIT_MASK;
      byte_q.push_back(b);
    end
  endfunction

  // Spread magnitudes over all widths so every encoded length shows up
  function automatic logic signed [WORD_BITS-1:0] rand_value();
    logic [WORD_BITS-1:0] r;
    int                   w;
    w = $urandom_range(0, WORD_BITS);
    r = {$urandom(), $urandom()};
    if (w < WORD_BITS) r = r & ((64'd1 << w) - 64'd1);
    return $urandom_range(0, 1) ? ~r : r;
  endfunction

  function automatic void queue_too_long();
    for (int i = 0; i < MAXB; i++) byte_q.push_back(8'($urandom()) | MORE_BIT_MASK);
  endfunction

  // Full-length number whose last byte sets bits past the word
  function automatic void queue_overflow();
    for (int i = 0; i < MAXB - 1; i++) byte_q.push_back(8'($urandom()) | MORE_BIT_MASK);
    byte_q.push_back(8'($urandom_range(2, 127)));
  endfunction

  function automatic void queue_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) byte_q.push_back(8'($urandom()));
  endfunction

  // One byte beat; valid stays up across back-to-back beats
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(b);
  endtask

  task automatic send_queue();
    while (byte_q.size() != 0) send_byte(byte_q.pop_front());
  endtask

  // Hold off the sender until every predicted word is out and the pipe is flushed
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic set_signed_mode(bit v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.signed_mode = v;
  endtask

  // Result side: random back-pressure, check every accepted word
  initial begin : result_sink
    int stall;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_word(out_value, out_status);
    end
  end

  initial begin : stimulus
    int unsigned sel;
    int unsigned target;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= 1'b0;
    in_valid   <= 1'b0;
    in_byte_in <= 8'h00;
    out_ready  <= 1'b0;
    no_idle    = 1'b0;
    sb         = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, signed mode from reset: single-byte extremes, word limits,
    // too long, last-byte overflow, redundant padding
    byte_q.push_back(8'h00);
    byte_q.push_back(8'h7F);
    queue_number(64'sh7FFF_FFFF_FFFF_FFFF, 0);
    queue_number(64'sh8000_0000_0000_0000, 0);
    repeat (MAXB) byte_q.push_back(8'hFF);
    repeat (MAXB - 1) byte_q.push_back(8'h80);
    byte_q.push_back(8'h02);
    queue_number(64'sd5, 3);
    send_queue();
    drain();

    // Directed, unsigned mode: negative rejected, positive passes,
    // overflow wins over a set sign
    set_signed_mode(1'b0);
    byte_q.push_back(8'h01);
    byte_q.push_back(8'h7E);
    byte_q.push_back(8'h81);
    repeat (MAXB - 2) byte_q.push_back(8'h80);
    byte_q.push_back(8'h7E);
    send_queue();
    drain();

    // Random phases, alternating signed_mode; mostly well-formed numbers
    for (int phase = 0; phase < 4; phase++) begin
      set_signed_mode(phase % 2 == 0);
      target = sb.bytes_seen + PHASE_BYTES;
      while (sb.bytes_seen < target) begin
        if ($urandom_range(0, 7) == 0) no_idle = ~no_idle;
        sel = $urandom_range(0, 99);
        if (sel < 70) queue_number(rand_value(),
                                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        else if (sel < 80) queue_too_long();
        else if (sel < 88) queue_overflow();
        else queue_noise();
        send_queue();
      end
      drain();
    end

    $display("Covered %0d bytes and %0d words in both signed_mode settings.",
             sb.bytes_seen, sb.words_seen);
    $display("Words by status: ok=%0d too_long=%0d overflow=%0d neg_unsigned=%0d",
             sb.by_status[ST_OK], sb.by_status[ST_TOO_LONG],
             sb.by_status[ST_OVERFLOW], sb.by_status[ST_NEG_UNS]);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("zigzag_varint_decoder test passed");
    end else begin
      $display("%0d mismatches, %0d words missing", sb.mismatches, sb.expected_q.size());
      $display("zigzag_varint_decoder test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("Timeout waiting for the decoder");
    $display("zigzag_varint_decoder test failed");
    $finish;
  end

endmodule
